[hw/rtl/llp_pkg.sv]
// shared types and codes for the ll(1) parser
`timescale 1ns / 1ps
package llp_pkg;

    localparam int SYM_W = 7;
    localparam int NT_BIT = 6;

    localparam logic [1:0] CMD_WR_ENTRY = 2'd0;
    localparam logic [1:0] CMD_WR_BODY  = 2'd1;
    localparam logic [1:0] CMD_START    = 2'd2;
    localparam logic [1:0] CMD_TOKEN    = 2'd3;

    localparam logic [2:0] EV_EXPANDED = 3'd0;
    localparam logic [2:0] EV_MATCHED  = 3'd1;
    localparam logic [2:0] EV_ACCEPTED = 3'd2;
    localparam logic [2:0] EV_NO_ENTRY = 3'd3;
    localparam logic [2:0] EV_MISMATCH = 3'd4;
    localparam logic [2:0] EV_OVERFLOW = 3'd5;
    localparam logic [2:0] EV_LIMIT    = 3'd6;
    localparam logic [2:0] EV_INACTIVE = 3'd7;

    typedef logic [SYM_W-1:0] sym_t;

endpackage

[hw/rtl/ll1_table_driven_parser.sv]
// LL(1) predictive parser top level: control sequencer, config registers, ports
//
// One input transaction is handled at a time. A token is decoded, then each
// stack top examined takes a stack read and a top check, and each expansion with an
// L-symbol body takes an entry read, then one stack push per cycle from the single
// body-memory read port. Each result is loaded into the output register, held
// off while a result still waits there. Results sit in an output register,
// so the next transaction is taken while one waits.
// After reset the entry memory is swept clean, all
// NUM_NONTERMINALS*(NUM_TERMINALS+1) cells (1056 by default), with s_axis_tready
// low; configuration writes are taken throughout.
`timescale 1ns / 1ps
module ll1_table_driven_parser
    import llp_pkg::*;
#(
    parameter int NUM_TERMINALS    = 32,
    parameter int NUM_NONTERMINALS = 32,
    parameter int MAX_BODY         = 8,
    parameter int STACK_DEPTH      = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // nonterminal[4:0] terminal[10:5] entry_valid[11] body_length[15:12]
    // body_position[18:16] symbol_is_nonterminal[19] symbol_index[25:20]
    input  logic [31:0] s_axis_tdata,
    // command[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // expanded_nonterminal[4:0] lookahead[10:5] applied_length[14:11]
    // stack_depth[21:15]
    output logic [23:0] m_axis_tdata,
    // event_res[2:0]
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int COLS   = NUM_TERMINALS + 1;
    localparam int CELLS  = NUM_NONTERMINALS * COLS;
    localparam int CELL_W = $clog2(CELLS);
    localparam int BODY_W = $clog2(CELLS * MAX_BODY);
    localparam int LEN_W  = $clog2(MAX_BODY + 1);
    localparam int ENT_W  = LEN_W + 1;
    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_FETCH = 4'd3;
    localparam logic [3:0] S_TOP   = 4'd4;
    localparam logic [3:0] S_ENTRY = 4'd5;
    localparam logic [3:0] S_PUSH  = 4'd6;
    localparam logic [3:0] S_EMIT  = 4'd7;

    // captured transaction
    logic [1:0] cmd_reg;
    logic [4:0] row_reg;
    logic [5:0] col_reg;
    logic       evld_reg;
    logic [3:0] blen_reg;
    logic [2:0] bpos_reg;
    logic       snt_reg;
    logic [5:0] sidx_reg;

    logic [3:0]        state_reg, state_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic              active_reg, active_next;
    logic [5:0]        exp_reg, exp_next;
    logic [4:0]        nt_reg, nt_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;

    logic [2:0]        pev_reg, pev_next;
    logic [4:0]        pnt_reg, pnt_next;
    logic [LEN_W-1:0]  plen_reg, plen_next;
    logic [SP_W-1:0]   pdep_reg, pdep_next;
    logic              plast_reg, plast_next;

    logic              mval_reg, mval_next;
    logic [2:0]        mev_reg;
    logic [4:0]        mnt_reg;
    logic [5:0]        mla_reg;
    logic [3:0]        mlen_reg;
    logic [6:0]        mdep_reg;
    logic              mlast_reg;

    logic [4:0] start_sym_reg;
    logic [5:0] max_exp_reg;

    logic              in_acc;
    logic              out_load;
    logic              clr_busy;

    logic              ent_we;
    logic [CELL_W-1:0] ent_waddr, ent_raddr, wr_cell, tok_cell;
    logic [ENT_W-1:0]  ent_wdata, ent_rdata;
    logic              body_we;
    logic [BODY_W-1:0] body_waddr, body_raddr;
    sym_t              body_wdata, body_rdata;
    logic              stk_we;
    logic [ADDR_W-1:0] stk_waddr, stk_raddr;
    sym_t              stk_wdata, stk_rdata;

    logic [LEN_W-1:0]  ent_len;
    logic [SP_W:0]     need_depth;
    logic              wr_ok;

    assign s_axis_tready = (state_reg == S_IDLE) && !clr_busy;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == S_EMIT) && (!mval_reg || m_axis_tready);

    assign wr_cell  = CELL_W'(row_reg * COLS + col_reg);
    assign tok_cell = CELL_W'(stk_rdata[5:0] * COLS + col_reg);
    assign wr_ok    = (row_reg < NUM_NONTERMINALS) && (col_reg <= NUM_TERMINALS);
    assign ent_len  = ent_rdata[LEN_W-1:0];
    assign need_depth = (SP_W+1)'(sp_reg) - 1'b1 + (SP_W+1)'(ent_len);

    // table write data and addresses
    always_comb
    begin
        ent_we     = (state_reg == S_EXEC) && (cmd_reg == CMD_WR_ENTRY) && wr_ok;
        ent_waddr  = wr_cell;
        ent_wdata  = {evld_reg,
                      (blen_reg > MAX_BODY) ? LEN_W'(MAX_BODY) : LEN_W'(blen_reg)};
        ent_raddr  = tok_cell;
        body_we    = (state_reg == S_EXEC) && (cmd_reg == CMD_WR_BODY) && wr_ok
                     && (bpos_reg < MAX_BODY);
        body_waddr = BODY_W'(wr_cell * MAX_BODY + bpos_reg);
        body_wdata = {snt_reg, sidx_reg};
        if (state_reg == S_ENTRY)
        begin
            body_raddr = BODY_W'(cell_reg * MAX_BODY + ent_len - 1);
        end
        else
        begin
            body_raddr = BODY_W'(cell_reg * MAX_BODY + pos_reg - 1);
        end
    end

    // stack port
    always_comb
    begin
        stk_we    = 1'b0;
        stk_waddr = sp_reg[ADDR_W-1:0];
        stk_wdata = body_rdata;
        stk_raddr = ADDR_W'(sp_reg - 1'b1);
        case (state_reg)
            S_EXEC:
            begin
                stk_we    = (cmd_reg == CMD_START);
                stk_waddr = '0;
                stk_wdata = SYM_W'(NUM_TERMINALS);
            end
            S_START:
            begin
                stk_we    = 1'b1;
                stk_waddr = ADDR_W'(1);
                stk_wdata = {1'b1, 1'b0, start_sym_reg};
            end
            S_PUSH:
            begin
                stk_we = 1'b1;
            end
            default:
            begin
                stk_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        sp_next     = sp_reg;
        active_next = active_reg;
        exp_next    = exp_reg;
        nt_next     = nt_reg;
        cell_next   = cell_reg;
        pos_next    = pos_reg;
        pev_next    = pev_reg;
        pnt_next    = pnt_reg;
        plen_next   = plen_reg;
        pdep_next   = pdep_reg;
        plast_next  = plast_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                if (cmd_reg == CMD_START)
                begin
                    state_next = S_START;
                end
                else if (cmd_reg == CMD_TOKEN)
                begin
                    exp_next = '0;
                    if (!active_reg)
                    begin
                        pev_next   = EV_INACTIVE;
                        pnt_next   = '0;
                        plen_next  = '0;
                        pdep_next  = sp_reg;
                        plast_next = 1'b1;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_START:
            begin
                sp_next     = SP_W'(2);
                active_next = 1'b1;
                state_next  = S_IDLE;
            end
            S_FETCH:
            begin
                if (sp_reg == '0)
                begin
                    active_next = 1'b0;
                    pev_next    = EV_MISMATCH;
                    pnt_next    = '0;
                    plen_next   = '0;
                    pdep_next   = '0;
                    plast_next  = 1'b1;
                    state_next  = S_EMIT;
                end
                else
                begin
                    state_next = S_TOP;
                end
            end
            S_TOP:
            begin
                pnt_next   = '0;
                plen_next  = '0;
                pdep_next  = sp_reg;
                plast_next = 1'b1;
                state_next = S_EMIT;
                if (!stk_rdata[NT_BIT])
                begin
                    if ((col_reg == NUM_TERMINALS) && (stk_rdata == SYM_W'(NUM_TERMINALS)))
                    begin
                        active_next = 1'b0;
                        pev_next    = EV_ACCEPTED;
                    end
                    else if (stk_rdata == {1'b0, col_reg})
                    begin
                        sp_next   = sp_reg - 1'b1;
                        pdep_next = sp_reg - 1'b1;
                        pev_next  = EV_MATCHED;
                    end
                    else
                    begin
                        active_next = 1'b0;
                        pev_next    = EV_MISMATCH;
                    end
                end
                else
                begin
                    nt_next  = stk_rdata[4:0];
                    pnt_next = stk_rdata[4:0];
                    if (exp_reg >= max_exp_reg)
                    begin
                        active_next = 1'b0;
                        pev_next    = EV_LIMIT;
                    end
                    else if ((stk_rdata[5:0] >= NUM_NONTERMINALS)
                             || (col_reg > NUM_TERMINALS))
                    begin
                        active_next = 1'b0;
                        pev_next    = EV_NO_ENTRY;
                    end
                    else
                    begin
                        cell_next  = tok_cell;
                        state_next = S_ENTRY;
                    end
                end
            end
            S_ENTRY:
            begin
                pnt_next   = nt_reg;
                plen_next  = '0;
                pdep_next  = sp_reg;
                plast_next = 1'b1;
                if (!ent_rdata[ENT_W-1])
                begin
                    active_next = 1'b0;
                    pev_next    = EV_NO_ENTRY;
                    state_next  = S_EMIT;
                end
                else if (need_depth > (SP_W+1)'(STACK_DEPTH))
                begin
                    active_next = 1'b0;
                    pev_next    = EV_OVERFLOW;
                    state_next  = S_EMIT;
                end
                else
                begin
                    sp_next    = sp_reg - 1'b1;
                    pev_next   = EV_EXPANDED;
                    plen_next  = ent_len;
                    plast_next = 1'b0;
                    if (ent_len == '0)
                    begin
                        pdep_next  = sp_reg - 1'b1;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        pos_next   = ent_len - 1'b1;
                        state_next = S_PUSH;
                    end
                end
            end
            S_PUSH:
            begin
                sp_next = sp_reg + 1'b1;
                if (pos_reg == '0)
                begin
                    pdep_next  = sp_reg + 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    pos_next = pos_reg - 1'b1;
                end
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    if (plast_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        exp_next   = exp_reg + 1'b1;
                        state_next = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mval_next = mval_reg;
        if (out_load)
        begin
            mval_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            mval_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            active_reg    <= 1'b0;
            mval_reg      <= 1'b0;
            start_sym_reg <= '0;
            max_exp_reg   <= 6'd63;
        end
        else
        begin
            state_reg  <= state_next;
            sp_reg     <= sp_next;
            active_reg <= active_next;
            mval_reg   <= mval_next;
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2])
                begin
                    max_exp_reg <= pwdata[5:0];
                end
                else
                begin
                    start_sym_reg <= pwdata[4:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg   <= exp_next;
        nt_reg    <= nt_next;
        cell_reg  <= cell_next;
        pos_reg   <= pos_next;
        pev_reg   <= pev_next;
        pnt_reg   <= pnt_next;
        plen_reg  <= plen_next;
        pdep_reg  <= pdep_next;
        plast_reg <= plast_next;
        if (in_acc)
        begin
            cmd_reg  <= s_axis_tuser;
            row_reg  <= s_axis_tdata[4:0];
            col_reg  <= s_axis_tdata[10:5];
            evld_reg <= s_axis_tdata[11];
            blen_reg <= s_axis_tdata[15:12];
            bpos_reg <= s_axis_tdata[18:16];
            snt_reg  <= s_axis_tdata[19];
            sidx_reg <= s_axis_tdata[25:20];
        end
        if (out_load)
        begin
            mev_reg   <= pev_reg;
            mnt_reg   <= pnt_reg;
            mla_reg   <= col_reg;
            mlen_reg  <= 4'(plen_reg);
            mdep_reg  <= 7'(pdep_reg);
            mlast_reg <= plast_reg;
        end
    end

    assign m_axis_tvalid = mval_reg;
    assign m_axis_tdata  = {2'b00, mdep_reg, mlen_reg, mla_reg, mnt_reg};
    assign m_axis_tuser  = mev_reg;
    assign m_axis_tlast  = mlast_reg;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {26'd0, max_exp_reg} : {27'd0, start_sym_reg};

    llp_table #(
        .CELLS    (CELLS),
        .MAX_BODY (MAX_BODY),
        .CELL_W   (CELL_W),
        .BODY_W   (BODY_W),
        .ENT_W    (ENT_W)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .ent_we     (ent_we),
        .ent_waddr  (ent_waddr),
        .ent_wdata  (ent_wdata),
        .ent_raddr  (ent_raddr),
        .ent_rdata  (ent_rdata),
        .body_we    (body_we),
        .body_waddr (body_waddr),
        .body_wdata (body_wdata),
        .body_raddr (body_raddr),
        .body_rdata (body_rdata),
        .busy       (clr_busy)
    );

    llp_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PUSH |-> sp_reg < SP_W'(STACK_DEPTH))
        else $error("push with full stack");

    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && plast_reg |=> state_reg == S_IDLE)
        else $error("final result did not end the token");

    a_clear_hold: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !s_axis_tready)
        else $error("input taken during table clear");

endmodule

[hw/rtl/llp_table.sv]
// parse table storage: entry memory with clearing sweep and body symbol memory
`timescale 1ns / 1ps
module llp_table
    import llp_pkg::*;
#(
    parameter int CELLS  = 1056,
    parameter int MAX_BODY = 8,
    parameter int CELL_W = 11,
    parameter int BODY_W = 14,
    parameter int ENT_W  = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ent_we,
    input  logic [CELL_W-1:0] ent_waddr,
    input  logic [ENT_W-1:0]  ent_wdata,
    input  logic [CELL_W-1:0] ent_raddr,
    output logic [ENT_W-1:0]  ent_rdata,
    input  logic              body_we,
    input  logic [BODY_W-1:0] body_waddr,
    input  sym_t              body_wdata,
    input  logic [BODY_W-1:0] body_raddr,
    output sym_t              body_rdata,
    output logic              busy
);

    logic [ENT_W-1:0] ent_mem [CELLS];
    sym_t             body_mem [CELLS*MAX_BODY];

    logic [CELL_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              busy_reg, busy_next;
    logic [ENT_W-1:0]  ent_rdata_reg;
    sym_t              body_rdata_reg;

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        busy_next    = busy_reg;
        if (busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == CELL_W'(CELLS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            busy_reg    <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            ent_mem[clr_cnt_reg] <= '0;
        end
        else if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        ent_rdata_reg <= ent_mem[ent_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (body_we)
        begin
            body_mem[body_waddr] <= body_wdata;
        end
        body_rdata_reg <= body_mem[body_raddr];
    end

    assign ent_rdata  = ent_rdata_reg;
    assign body_rdata = body_rdata_reg;
    assign busy       = busy_reg;

endmodule

[hw/rtl/llp_stack.sv]
// symbol stack memory, one write and one registered read port
`timescale 1ns / 1ps
module llp_stack
    import llp_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int ADDR_W = 6
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  sym_t              wdata,
    input  logic [ADDR_W-1:0] raddr,
    output sym_t              rdata
);

    sym_t mem [STACK_DEPTH];
    sym_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[tb/parse_checker.sv]
// result predictor and scoreboard for the ll(1) parser testbench
`timescale 1ns / 1ps
module parse_checker
    import llp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          pending,
    output int          events_seen,
    output logic        parse_live,
    output sym_t        top_sym
);

    localparam int NT_N    = 32;
    localparam int END_MK  = 32;
    localparam int COLS    = END_MK + 1;
    localparam int BODY_N  = 8;
    localparam int DEPTH   = 64;
    localparam logic [2:0] ADDR_START = 3'd0;
    localparam logic [2:0] ADDR_LIMIT = 3'd4;

    typedef struct packed {
        logic [2:0] ev;
        logic [4:0] nt;
        logic [5:0] la;
        logic [3:0] len;
        logic [6:0] depth;
        logic       last;
    } parse_event_t;

    logic [4:0]   cell_tab [0:NT_N*COLS-1];
    sym_t         body_tab [0:NT_N*COLS*BODY_N-1];
    sym_t         stk [0:DEPTH-1];
    int           sp;
    logic         live;
    logic [4:0]   start_nt;
    logic [5:0]   exp_cap;
    parse_event_t want_q[$];

    initial
    begin
        errors = 0;
        pending = 0;
        events_seen = 0;
        parse_live = 1'b0;
        top_sym = '0;
    end

    function automatic void post(logic [2:0] ev, int nt, logic [5:0] la, int len, logic fin);
        parse_event_t e;
        e.ev = ev;
        e.nt = nt[4:0];
        e.la = la;
        e.len = len[3:0];
        e.depth = sp[6:0];
        e.last = fin;
        want_q.push_back(e);
    endfunction

    // walk the stack for one token, queueing every event it causes
    function automatic void parse_token(logic [5:0] col);
        int   n_exp;
        sym_t tos;
        int   nt;
        int   cidx;
        int   len;
        n_exp = 0;
        if (!live)
        begin
            post(EV_INACTIVE, 0, col, 0, 1'b1);
            return;
        end
        while (1)
        begin
            if (sp == 0)
            begin
                live = 1'b0;
                post(EV_MISMATCH, 0, col, 0, 1'b1);
                return;
            end
            tos = stk[sp-1];
            if (!tos[NT_BIT])
            begin
                if (col == END_MK && tos == END_MK)
                begin
                    live = 1'b0;
                    post(EV_ACCEPTED, 0, col, 0, 1'b1);
                end
                else if (tos[5:0] == col)
                begin
                    sp--;
                    post(EV_MATCHED, 0, col, 0, 1'b1);
                end
                else
                begin
                    live = 1'b0;
                    post(EV_MISMATCH, 0, col, 0, 1'b1);
                end
                return;
            end
            nt = tos[5:0];
            if (n_exp >= exp_cap)
            begin
                live = 1'b0;
                post(EV_LIMIT, nt, col, 0, 1'b1);
                return;
            end
            cidx = nt * COLS + col;
            if (nt >= NT_N || col > END_MK || !cell_tab[cidx][4])
            begin
                live = 1'b0;
                post(EV_NO_ENTRY, nt, col, 0, 1'b1);
                return;
            end
            len = cell_tab[cidx][3:0];
            if (sp - 1 + len > DEPTH)
            begin
                live = 1'b0;
                post(EV_OVERFLOW, nt, col, 0, 1'b1);
                return;
            end
            sp--;
            for (int i = len; i > 0; i--)
            begin
                stk[sp] = body_tab[cidx*BODY_N + i - 1];
                sp++;
            end
            n_exp++;
            post(EV_EXPANDED, nt, col, len, 1'b0);
        end
    endfunction

    always @(posedge clk)
    begin
        parse_event_t got;
        parse_event_t exp_ev;
        logic [4:0]   row;
        logic [5:0]   col;
        int           cidx;
        int           blen;
        if (!rst_n)
        begin
            for (int i = 0; i < NT_N*COLS; i++)
                cell_tab[i] = '0;
            sp = 0;
            live = 1'b0;
            start_nt = '0;
            exp_cap = 6'd63;
            want_q.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                events_seen++;
                got = '{m_axis_tuser, m_axis_tdata[4:0], m_axis_tdata[10:5],
                        m_axis_tdata[14:11], m_axis_tdata[21:15], m_axis_tlast};
                if (want_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result ev=%0d nt=%0d la=%0d len=%0d depth=%0d last=%0d",
                                 $realtime, got.ev, got.nt, got.la, got.len, got.depth, got.last);
                end
                else
                begin
                    exp_ev = want_q.pop_front();
                    if (got !== exp_ev)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: result mismatch exp ev=%0d nt=%0d la=%0d len=%0d depth=%0d last=%0d / got ev=%0d nt=%0d la=%0d len=%0d depth=%0d last=%0d",
                                     $realtime, exp_ev.ev, exp_ev.nt, exp_ev.la, exp_ev.len,
                                     exp_ev.depth, exp_ev.last, got.ev, got.nt, got.la, got.len,
                                     got.depth, got.last);
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == ADDR_START)
                    start_nt = pwdata[4:0];
                else if (paddr == ADDR_LIMIT)
                    exp_cap = pwdata[5:0];
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                row = s_axis_tdata[4:0];
                col = s_axis_tdata[10:5];
                cidx = row * COLS + col;
                case (s_axis_tuser)
                    CMD_WR_ENTRY:
                        if (col <= END_MK)
                        begin
                            blen = s_axis_tdata[15:12];
                            if (blen > BODY_N)
                                blen = BODY_N;
                            cell_tab[cidx] = {s_axis_tdata[11], blen[3:0]};
                        end
                    CMD_WR_BODY:
                        if (col <= END_MK)
                            body_tab[cidx*BODY_N + s_axis_tdata[18:16]] =
                                {s_axis_tdata[19], s_axis_tdata[25:20]};
                    CMD_START:
                    begin
                        stk[0] = END_MK;
                        stk[1] = {1'b1, 1'b0, start_nt};
                        sp = 2;
                        live = 1'b1;
                    end
                    default:
                        parse_token(col);
                endcase
            end
        end
        pending = want_q.size();
        parse_live = live;
        top_sym = (sp > 0) ? stk[sp-1] : '0;
    end

endmodule

[tb/tb_ll1_table_driven_parser.sv]
// testbench top for the ll(1) parser: stimulus, handshake idling and verdict
`timescale 1ns / 1ps
module tb_ll1_table_driven_parser;
    import llp_pkg::*;

    localparam int END_MK     = 32;
    localparam int STALL_CAP  = 6000;
    localparam logic [2:0] ADDR_START = 3'd0;
    localparam logic [2:0] ADDR_LIMIT = 3'd4;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int   errors;
    int   pending;
    int   events_seen;
    logic parse_live;
    sym_t top_sym;

    logic calm;
    int   stall_cycles;
    int   items_sent;
    logic ent_ok [0:31][0:32];
    int   nt_pool [0:5];
    int   t_pool [0:4];

    ll1_table_driven_parser u_top (.*);

    parse_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(negedge clk)
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 17);

    // nothing accepted on either side for too long means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_CAP)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send(logic [1:0] cmd, logic [31:0] data);
        while (!calm && $urandom_range(0, 99) < 17)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= data;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic put_body(int nt, int col, int pos, logic is_nt, int idx);
        send(CMD_WR_BODY, {6'd0, idx[5:0], is_nt, pos[2:0], 4'd0, 1'b0, col[5:0], nt[4:0]});
    endtask

    task automatic put_entry(int nt, int col, logic ok, int len);
        send(CMD_WR_ENTRY, {16'd0, len[3:0], ok, col[5:0], nt[4:0]});
        ent_ok[nt][col] = ok;
    endtask

    task automatic send_token(int col);
        send(CMD_TOKEN, {21'd0, col[5:0], 5'd0});
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(negedge clk);
    endtask

    // random production: bodies usually open with the lookahead terminal
    task automatic add_rule(int nt, int col);
        int   len;
        int   bl;
        int   r;
        logic is_nt;
        int   idx;
        r = $urandom_range(0, 99);
        len = (r < 15) ? 0 : (r < 22) ? $urandom_range(9, 15) : $urandom_range(1, 8);
        bl = (len > 8) ? 8 : len;
        for (int p = 0; p < bl; p++)
        begin
            if (p == 0 && $urandom_range(0, 99) < 70)
            begin
                is_nt = 1'b0;
                idx = col;
            end
            else if ($urandom_range(0, 99) < 40)
            begin
                is_nt = 1'b1;
                idx = ($urandom_range(0, 99) < 3) ? END_MK : nt_pool[$urandom_range(0, 5)];
            end
            else
            begin
                is_nt = 1'b0;
                idx = t_pool[$urandom_range(0, 4)];
            end
            put_body(nt, col, p, is_nt, idx);
        end
        put_entry(nt, col, $urandom_range(0, 99) < 92, len);
    endtask

    function automatic int pick_token();
        int cols [$];
        if (!parse_live || $urandom_range(0, 99) < 12)
            return $urandom_range(0, END_MK);
        if (!top_sym[NT_BIT])
            return top_sym[5:0];
        if (top_sym[5:0] < 32)
            for (int c = 0; c <= END_MK; c++)
                if (ent_ok[top_sym[4:0]][c])
                    cols.push_back(c);
        if (cols.size() == 0)
            return $urandom_range(0, END_MK);
        return cols[$urandom_range(0, cols.size() - 1)];
    endfunction

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_WR_ENTRY;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        calm = 1'b0;
        stall_cycles = 0;
        items_sent = 0;
        for (int r = 0; r < 32; r++)
            for (int c = 0; c <= END_MK; c++)
                ent_ok[r][c] = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: idle token, saturated body, out-of-range nonterminal, epsilon, empty cell
        reg_write(ADDR_START, 32'd31);
        send_token(END_MK);
        put_body(31, END_MK, 0, 1'b1, END_MK);
        for (int p = 1; p < 8; p++)
            put_body(31, END_MK, p, 1'b0, p);
        put_entry(31, END_MK, 1'b1, 15);
        send(CMD_START, '0);
        send_token(END_MK);
        put_entry(31, END_MK, 1'b1, 0);
        send(CMD_START, '0);
        send_token(END_MK);
        put_entry(31, END_MK, 1'b0, 0);
        send(CMD_START, '0);
        send_token(END_MK);
        send(CMD_START, '0);
        send_token(5);
        send_token(7);

        for (int ph = 0; ph < 3; ph++)
        begin
            drain();
            calm = (ph == 1);
            for (int k = 0; k < 6; k++)
                nt_pool[k] = $urandom_range(0, 31);
            if (ph == 2)
                nt_pool[0] = 31;
            for (int k = 0; k < 4; k++)
                t_pool[k] = $urandom_range(0, 31);
            t_pool[4] = END_MK;
            reg_write(ADDR_START, nt_pool[0]);
            reg_write(ADDR_LIMIT, (ph == 0) ? 63 : (ph == 1) ? 1 : $urandom_range(2, 6));
            for (int k = 0; k < 6; k++)
                add_rule(nt_pool[$urandom_range(0, 5)], t_pool[$urandom_range(0, 4)]);
            for (int k = 0; k < 5; k++)
                add_rule(nt_pool[0], t_pool[k]);
            for (int k = 0; k < 55; k++)
            begin
                if ((!parse_live && $urandom_range(0, 99) < 70) || $urandom_range(0, 99) < 3)
                    send(CMD_START, '0);
                else
                    send_token(pick_token());
            end
        end

        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (30) @(negedge clk);
        $display("run covered %0d input transactions and %0d parser events", items_sent,
                 events_seen);
        $display("three grammars under start symbol and expansion limit settings incl. extremes");
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
